[rtl/core/dcp_idr_pkg.sv]
// Types and constants shared by the DCP identify response parser.
package dcp_idr_pkg;

  localparam int unsigned EthHeaderBytes   = 14;
  localparam int unsigned DcpHeaderBytes   = 12;
  localparam int unsigned DataLengthOffset = 10;
  localparam int unsigned DataStart        = EthHeaderBytes + DcpHeaderBytes;

  localparam logic [15:0] POS_LIMIT = 16'hFFFF;

  // configuration register indexes
  localparam logic [2:0] CFG_FRAME_ID     = 3'd0;
  localparam logic [2:0] CFG_SERVICE_ID   = 3'd1;
  localparam logic [2:0] CFG_SERVICE_TYPE = 3'd2;
  localparam logic [2:0] CFG_IP_CODE      = 3'd3;
  localparam logic [2:0] CFG_NAME_CODE    = 3'd4;
  localparam logic [2:0] CFG_HWID_CODE    = 3'd5;

  // block walk phases
  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_PAD  = 2'd2;

  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  name_byte;
    logic [7:0]  name_index;
    logic        name_restart;
    logic        accepted;
    logic [47:0] source_mac;
    logic        ip_valid;
    logic [31:0] ip_address;
    logic [15:0] hw_vendor;
    logic [15:0] hw_device;
    logic        final_res;
  } result_t;

endpackage

[rtl/core/dcp_identify_response_parser.sv]
// DCP identify response parser: frame byte walk, field capture and result queue.
// Data path: a byte is registered at acceptance, parsed from that input register, and its
// results are written to the result queue, whose occupancy drives out_valid.
// Throughput: one byte per cycle while the result queue has two free entries; a byte that
// yields a name byte and the summary writes two entries into the four-entry result queue.
// Reset: synchronous, active low; clears the parser state, the queue and the registers
// to their default codes.
module dcp_identify_response_parser
  import dcp_idr_pkg::*;
#(
  parameter int unsigned NAME_CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_name_byte,
  output logic [7:0]  out_name_index,
  output logic        out_name_restart,
  output logic        out_accepted,
  output logic [47:0] out_source_mac,
  output logic        out_ip_valid,
  output logic [31:0] out_ip_address,
  output logic [15:0] out_hw_vendor,
  output logic [15:0] out_hw_device,
  output logic        out_final_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned NameLimit = NAME_CAPACITY - 1;

  // configuration registers
  logic [15:0] frame_id_r;
  logic [7:0]  service_id_r;
  logic [7:0]  service_type_r;
  logic [15:0] ip_code_r;
  logic [15:0] name_code_r;
  logic [15:0] hwid_code_r;

  // input stage
  logic       hold_r;
  logic [7:0] byte_r;
  logic       last_r;

  // parser state
  logic [15:0] byte_position_r, byte_position_nxt;
  logic [16:0] region_end_r, region_end_nxt;
  logic        header_ok_r, header_ok_nxt;
  logic [1:0]  block_phase_r, block_phase_nxt;
  logic [15:0] block_code_r, block_code_nxt;
  logic [15:0] block_length_r, block_length_nxt;
  logic [15:0] block_offset_r, block_offset_nxt;
  logic [47:0] mac_shift_r, mac_shift_nxt;
  logic [31:0] ip_shift_r, ip_shift_nxt;
  logic        ip_seen_r, ip_seen_nxt;
  logic [31:0] vendor_device_r, vendor_device_nxt;
  logic [31:0] field_work_r, field_work_nxt;

  // result queue
  result_t     queue_r [4];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  rd_ptr_r;
  logic [2:0]  count_r;

  logic        go;
  logic        pop;
  logic        name_push;
  result_t     name_res;
  result_t     sum_res;
  logic [16:0] off_inc;
  logic        acc;

  assign cfg_ready = 1'b1;
  assign go        = hold_r && (count_r <= 3'd2);
  assign in_stall  = hold_r && !go;
  assign out_valid = (count_r != 3'd0);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_id_r     <= 16'hFEFF;
      service_id_r   <= 8'd5;
      service_type_r <= 8'd1;
      ip_code_r      <= 16'h0102;
      name_code_r    <= 16'h0202;
      hwid_code_r    <= 16'h0203;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_ID:     frame_id_r     <= cfg_data;
        CFG_SERVICE_ID:   service_id_r   <= cfg_data[7:0];
        CFG_SERVICE_TYPE: service_type_r <= cfg_data[7:0];
        CFG_IP_CODE:      ip_code_r      <= cfg_data;
        CFG_NAME_CODE:    name_code_r    <= cfg_data;
        CFG_HWID_CODE:    hwid_code_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_r <= 1'b1;
    end else if (go) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  always_comb begin
    byte_position_nxt = byte_position_r;
    region_end_nxt    = region_end_r;
    header_ok_nxt     = header_ok_r;
    block_phase_nxt   = block_phase_r;
    block_code_nxt    = block_code_r;
    block_length_nxt  = block_length_r;
    block_offset_nxt  = block_offset_r;
    mac_shift_nxt     = mac_shift_r;
    ip_shift_nxt      = ip_shift_r;
    ip_seen_nxt       = ip_seen_r;
    vendor_device_nxt = vendor_device_r;
    field_work_nxt    = field_work_r;
    name_push         = 1'b0;
    name_res          = '0;
    off_inc           = {1'b0, block_offset_r} + 17'd1;

    if (byte_position_r >= 16'd6 && byte_position_r < 16'd12) begin
      mac_shift_nxt = {mac_shift_r[39:0], byte_r};
    end else if (byte_position_r == 16'(EthHeaderBytes)) begin
      if (byte_r != frame_id_r[15:8]) header_ok_nxt = 1'b0;
    end else if (byte_position_r == 16'(EthHeaderBytes + 1)) begin
      if (byte_r != frame_id_r[7:0]) header_ok_nxt = 1'b0;
    end else if (byte_position_r == 16'(EthHeaderBytes + 2)) begin
      if (byte_r != service_id_r) header_ok_nxt = 1'b0;
    end else if (byte_position_r == 16'(EthHeaderBytes + 3)) begin
      if (byte_r != service_type_r) header_ok_nxt = 1'b0;
    end else if (byte_position_r == 16'(EthHeaderBytes + DataLengthOffset)) begin
      region_end_nxt = 17'(DataStart) + {1'b0, byte_r, 8'd0};
    end else if (byte_position_r == 16'(EthHeaderBytes + DataLengthOffset + 1)) begin
      region_end_nxt = region_end_r + {9'd0, byte_r};
    end

    if (header_ok_r && byte_position_r >= 16'(DataStart) && byte_position_r < POS_LIMIT) begin
      case (block_phase_r)
        PH_BODY: begin
          if (block_code_r == ip_code_r && block_length_r >= 16'd14) begin
            if (block_offset_r >= 16'd2 && block_offset_r <= 16'd5) begin
              field_work_nxt = {field_work_r[23:0], byte_r};
              if (block_offset_r == 16'd5) begin
                ip_shift_nxt = {field_work_r[23:0], byte_r};
                ip_seen_nxt  = 1'b1;
              end
            end
          end else if (block_code_r == name_code_r) begin
            if (block_offset_r < 16'(NameLimit)) begin
              name_push             = 1'b1;
              name_res.result_kind  = KIND_NAME;
              name_res.name_byte    = byte_r;
              name_res.name_index   = block_offset_r[7:0];
              name_res.name_restart = (block_offset_r == 16'd0);
            end
          end else if (block_code_r == hwid_code_r && block_length_r >= 16'd4) begin
            if (block_offset_r <= 16'd3) begin
              field_work_nxt = {field_work_r[23:0], byte_r};
              if (block_offset_r == 16'd3) begin
                vendor_device_nxt = {field_work_r[23:0], byte_r};
              end
            end
          end
          if (off_inc >= {1'b0, block_length_r}) begin
            block_offset_nxt = '0;
            block_phase_nxt  = block_length_r[0] ? PH_PAD : PH_HEAD;
          end else begin
            block_offset_nxt = off_inc[15:0];
          end
        end
        PH_PAD: begin
          block_phase_nxt  = PH_HEAD;
          block_offset_nxt = '0;
        end
        default: begin
          if ({1'b0, byte_position_r} < region_end_r) begin
            if (block_offset_r < 16'd2) begin
              block_code_nxt = {block_code_r[7:0], byte_r};
            end else begin
              block_length_nxt = {block_length_r[7:0], byte_r};
            end
            if (block_offset_r == 16'd3) begin
              block_offset_nxt = '0;
              field_work_nxt   = '0;
              block_phase_nxt  = (block_length_nxt != 16'd0) ? PH_BODY : PH_HEAD;
            end else begin
              block_offset_nxt = off_inc[15:0];
            end
          end
        end
      endcase
    end

    if (byte_position_r < POS_LIMIT) begin
      byte_position_nxt = byte_position_r + 16'd1;
    end

    acc                  = header_ok_nxt && (byte_position_r >= 16'(DataStart - 1));
    sum_res              = '0;
    sum_res.result_kind  = KIND_SUMMARY;
    sum_res.accepted     = acc;
    sum_res.source_mac   = mac_shift_nxt;
    sum_res.ip_valid     = acc && ip_seen_nxt;
    sum_res.ip_address   = (acc && ip_seen_nxt) ? ip_shift_nxt : 32'd0;
    sum_res.hw_vendor    = acc ? vendor_device_nxt[31:16] : 16'd0;
    sum_res.hw_device    = acc ? vendor_device_nxt[15:0] : 16'd0;
    sum_res.final_res    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && last_r)) begin
      byte_position_r <= '0;
      region_end_r    <= '0;
      header_ok_r     <= 1'b1;
      block_phase_r   <= PH_HEAD;
      block_code_r    <= '0;
      block_length_r  <= '0;
      block_offset_r  <= '0;
      mac_shift_r     <= '0;
      ip_shift_r      <= '0;
      ip_seen_r       <= 1'b0;
      vendor_device_r <= '0;
      field_work_r    <= '0;
    end else if (go) begin
      byte_position_r <= byte_position_nxt;
      region_end_r    <= region_end_nxt;
      header_ok_r     <= header_ok_nxt;
      block_phase_r   <= block_phase_nxt;
      block_code_r    <= block_code_nxt;
      block_length_r  <= block_length_nxt;
      block_offset_r  <= block_offset_nxt;
      mac_shift_r     <= mac_shift_nxt;
      ip_shift_r      <= ip_shift_nxt;
      ip_seen_r       <= ip_seen_nxt;
      vendor_device_r <= vendor_device_nxt;
      field_work_r    <= field_work_nxt;
    end
  end

  // result queue: up to two writes per parsed byte, one read per cycle while out_stall is low
  logic [1:0] push_cnt;
  assign push_cnt = go ? ({1'b0, name_push} + {1'b0, last_r}) : 2'd0;

  always_ff @(posedge clk) begin
    if (go) begin
      if (name_push) begin
        queue_r[wr_ptr_r] <= name_res;
        if (last_r) queue_r[wr_ptr_r + 2'd1] <= sum_res;
      end else if (last_r) begin
        queue_r[wr_ptr_r] <= sum_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_cnt;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r <= count_r + {1'b0, push_cnt} - {2'd0, pop};
    end
  end

  result_t head;
  assign head = queue_r[rd_ptr_r];

  assign out_result_kind  = head.result_kind;
  assign out_name_byte    = head.name_byte;
  assign out_name_index   = head.name_index;
  assign out_name_restart = head.name_restart;
  assign out_accepted     = head.accepted;
  assign out_source_mac   = head.source_mac;
  assign out_ip_valid     = head.ip_valid;
  assign out_ip_address   = head.ip_address;
  assign out_hw_vendor    = head.hw_vendor;
  assign out_hw_device    = head.hw_device;
  assign out_final_res    = head.final_res;

endmodule
